>>> rtl/core/uglr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Uniform grid resampler package
// Shared constants, request and status codes, and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package uglr_pkg;

   // Default table capacity in points.
   localparam int unsigned UGLR_TABLE_DEPTH = 1024;

   // Width of energies and sigmas.
   localparam int unsigned DATA_WIDTH = 32;

   // Grid spacing after reset: 1 eV with 16 fractional bits.
   localparam logic [DATA_WIDTH-1:0] STEP_RESET = 32'h0001_0000;

   // The divider produces one quotient bit per cycle.
   localparam int unsigned DIV_STEPS       = DATA_WIDTH;
   localparam int unsigned DIV_COUNT_WIDTH = $clog2(DIV_STEPS);

   // Request actions.
   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   // Response status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_FEW      = 2'd2;
   localparam logic [1:0] STATUS_FINISHED = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic dispatch;
      logic probe;
      logic compare;
      logic fetch_lo;
      logic fetch_hi;
      logic prep;
      logic mul;
      logic div_setup;
      logic divide;
      logic finish;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_search;
      logic search_done;
      logic div_last;
   } stat_type;

endpackage : uglr_pkg
`default_nettype wire

>>> rtl/core/uniform_grid_linear_resampler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Uniform grid linear resampler
// Loads ascending (energy, sigma) points and steps out a uniform energy grid
// from the first to the last table energy with linearly interpolated sigma.
//
//   Channel   Direction  Handshake            Payload
//   req       in         req_valid/ready      action, point energy, sigma
//   rsp       out        rsp_valid/ready      grid energy, sigma, last, status
//   csr       in         csr_wr_en            energy step (no read-back)
//
// One request is processed at a time. Loads, clears, error reads and reads
// at either table end go from dispatch straight to the response. Interior
// grid reads first run S binary search probes, where S <= clog2(points) + 1,
// through the single table read port, then the bracket fetch, multiply and
// restoring divider; the divider takes the longest.
// Synchronous reset empties the table and restarts the grid; step = 1 eV.
// A stalled response holds in the output register while the next request
// is taken and worked on up to its own response.
// ----------------------------------------------------------------------------
module uniform_grid_linear_resampler
   import uglr_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = UGLR_TABLE_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_action,
   input  wire logic [DATA_WIDTH-1:0] req_point_energy,
   input  wire logic [DATA_WIDTH-1:0] req_point_sigma,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [DATA_WIDTH-1:0]      rsp_grid_energy,
   output logic [DATA_WIDTH-1:0]      rsp_grid_sigma,
   output logic                       rsp_last_point,
   output logic [1:0]                 rsp_status,
   input  wire logic                  csr_wr_en,
   input  wire logic [DATA_WIDTH-1:0] csr_wr_data
);

   cmd_type  cmd;
   stat_type stat;

   // Request sequencing.
   uglr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Tables, grid state and interpolation arithmetic.
   uglr_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_action       (req_action),
      .req_point_energy (req_point_energy),
      .req_point_sigma  (req_point_sigma),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_grid_energy  (rsp_grid_energy),
      .rsp_grid_sigma   (rsp_grid_sigma),
      .rsp_last_point   (rsp_last_point),
      .rsp_status       (rsp_status)
   );

endmodule : uniform_grid_linear_resampler
`default_nettype wire

>>> rtl/core/uglr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Uniform grid resampler controller
// Sequences one request at a time through dispatch, table search, bracket
// fetch, multiply and division, and owns the response valid flag.
// ----------------------------------------------------------------------------
module uglr_ctrl
   import uglr_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [11:0] {
      S_IDLE      = 12'b0000_0000_0001,
      S_DISPATCH  = 12'b0000_0000_0010,
      S_PROBE     = 12'b0000_0000_0100,
      S_COMPARE   = 12'b0000_0000_1000,
      S_FETCH_LO  = 12'b0000_0001_0000,
      S_FETCH_HI  = 12'b0000_0010_0000,
      S_PREP      = 12'b0000_0100_0000,
      S_MUL       = 12'b0000_1000_0000,
      S_DIV_SETUP = 12'b0001_0000_0000,
      S_DIVIDE    = 12'b0010_0000_0000,
      S_FINISH    = 12'b0100_0000_0000,
      S_EMIT      = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The output register can take a new response when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cmd.dispatch = 1'b1;
            state_in     = stat.need_search ? S_PROBE : S_EMIT;
         end
         S_PROBE: begin
            if (stat.search_done) begin
               state_in = S_FETCH_LO;
            end else begin
               cmd.probe = 1'b1;
               state_in  = S_COMPARE;
            end
         end
         S_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = S_PROBE;
         end
         S_FETCH_LO: begin
            cmd.fetch_lo = 1'b1;
            state_in     = S_FETCH_HI;
         end
         S_FETCH_HI: begin
            cmd.fetch_hi = 1'b1;
            state_in     = S_PREP;
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIV_SETUP;
         end
         S_DIV_SETUP: begin
            cmd.div_setup = 1'b1;
            state_in      = S_DIVIDE;
         end
         S_DIVIDE: begin
            cmd.divide = 1'b1;
            if (stat.div_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule : uglr_ctrl
`default_nettype wire

>>> rtl/core/uglr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Uniform grid resampler datapath
// Holds the point tables, the grid position and the interpolation unit: a
// binary search over the energy table, a 32 x 32 multiplier and a restoring
// divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module uglr_datapath
   import uglr_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = UGLR_TABLE_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output stat_type                   stat,
   input  wire logic [1:0]            req_action,
   input  wire logic [DATA_WIDTH-1:0] req_point_energy,
   input  wire logic [DATA_WIDTH-1:0] req_point_sigma,
   input  wire logic                  csr_wr_en,
   input  wire logic [DATA_WIDTH-1:0] csr_wr_data,
   output logic [DATA_WIDTH-1:0]      rsp_grid_energy,
   output logic [DATA_WIDTH-1:0]      rsp_grid_sigma,
   output logic                       rsp_last_point,
   output logic [1:0]                 rsp_status
);

   localparam int unsigned AddrWidth  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CountWidth = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned W          = DATA_WIDTH;

   // Point tables.
   logic [W-1:0] energy_mem [TABLE_DEPTH];
   logic [W-1:0] sigma_mem  [TABLE_DEPTH];

   // Latched request.
   logic [1:0]   act_ff;
   logic [W-1:0] pe_ff;
   logic [W-1:0] ps_ff;

   // Table and grid state.
   logic [W-1:0]          step_ff;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [W:0]            offset_ff, offset_in;
   logic                  finished_ff, finished_in;
   logic [W-1:0]          emin_ff, emax_ff, sfirst_ff, slast_ff;

   // Result being built.
   logic [W-1:0] res_energy_ff, res_energy_in;
   logic [W-1:0] res_sigma_ff, res_sigma_in;
   logic         res_last_ff, res_last_in;
   logic [1:0]   res_status_ff, res_status_in;

   // Search, fetch and arithmetic registers.
   logic [CountWidth-1:0]      first_ff, first_in;
   logic [CountWidth-1:0]      cnt_ff, cnt_in;
   logic [AddrWidth-1:0]       hi_ff;
   logic [W-1:0]               e_rd_ff, s_rd_ff;
   logic [W-1:0]               e0_ff, s0_ff;
   logic [W-1:0]               den_ff, num_ff, diff_ff;
   logic                       down_ff;
   logic [2*W-1:0]             prod_ff;
   logic [W-1:0]               rem_ff, rem_in;
   logic [W-1:0]               low_ff, low_in;
   logic [DIV_COUNT_WIDTH-1:0] div_cnt_ff, div_cnt_in;

   // Combinational helpers.
   logic                  table_full, few_points, mem_we, rd_en;
   logic [W:0]            grid_sum;
   logic                  at_end;
   logic [W-1:0]          ge_next, step_eff;
   logic [CountWidth-1:0] half, probe_sum, last_idx, hi_calc;
   logic [AddrWidth-1:0]  rd_addr;
   logic                  flat;
   logic [W-1:0]          den_c, num_c, diff_c;
   logic [2*W-1:0]        dividend;
   logic [W:0]            trial, trial_sub;
   logic                  trial_fits;

   // Grid position and request classification.
   assign table_full = (count_ff == CountWidth'(TABLE_DEPTH));
   assign few_points = (count_ff < CountWidth'(2));
   assign grid_sum   = {1'b0, emin_ff} + offset_ff;
   assign at_end     = (grid_sum >= {1'b0, emax_ff});
   assign ge_next    = at_end ? emax_ff : grid_sum[W-1:0];
   assign step_eff   = (step_ff == '0) ? W'(1) : step_ff;
   assign mem_we     = cmd.dispatch && (act_ff == ACT_LOAD) && !table_full;

   assign stat.need_search = (act_ff == ACT_READ) && !few_points && !finished_ff
                           && (ge_next > emin_ff) && (ge_next < emax_ff);

   // Request latch and grid spacing register.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         act_ff <= req_action;
         pe_ff  <= req_point_energy;
         ps_ff  <= req_point_sigma;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
      end else if (csr_wr_en) begin
         step_ff <= csr_wr_data;
      end
   end

   // Dispatch of loads, clears and grid reads, and the final sigma.
   always_comb begin
      count_in      = count_ff;
      offset_in     = offset_ff;
      finished_in   = finished_ff;
      res_energy_in = res_energy_ff;
      res_sigma_in  = res_sigma_ff;
      res_last_in   = res_last_ff;
      res_status_in = res_status_ff;
      if (cmd.dispatch) begin
         res_energy_in = '0;
         res_sigma_in  = '0;
         res_last_in   = 1'b0;
         res_status_in = STATUS_OK;
         case (act_ff)
            ACT_LOAD: begin
               if (table_full) begin
                  res_status_in = STATUS_FULL;
               end else begin
                  count_in = count_ff + CountWidth'(1);
               end
               offset_in   = '0;
               finished_in = 1'b0;
            end
            ACT_CLEAR: begin
               count_in    = '0;
               offset_in   = '0;
               finished_in = 1'b0;
            end
            ACT_READ: begin
               if (few_points) begin
                  res_status_in = STATUS_FEW;
               end else if (finished_ff) begin
                  res_status_in = STATUS_FINISHED;
               end else begin
                  res_energy_in = ge_next;
                  res_last_in   = at_end;
                  if (at_end) begin
                     finished_in = 1'b1;
                  end else begin
                     offset_in = offset_ff + {1'b0, step_eff};
                  end
                  // Endpoint clamp; interior points are overwritten later.
                  res_sigma_in = (ge_next <= emin_ff) ? sfirst_ff : slast_ff;
               end
            end
            default: begin
            end
         endcase
      end else if (cmd.finish) begin
         res_sigma_in = down_ff ? (s0_ff - low_ff) : (s0_ff + low_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         offset_ff   <= '0;
         finished_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         offset_ff   <= offset_in;
         finished_ff <= finished_in;
      end
   end

   always_ff @(posedge clock) begin
      res_energy_ff <= res_energy_in;
      res_sigma_ff  <= res_sigma_in;
      res_last_ff   <= res_last_in;
      res_status_ff <= res_status_in;
   end

   // The first and last points are kept in registers for the endpoint clamp.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         if (count_ff == '0) begin
            emin_ff   <= pe_ff;
            sfirst_ff <= ps_ff;
         end
         emax_ff  <= pe_ff;
         slast_ff <= ps_ff;
      end
   end

   // Binary search for the first entry above the grid energy.
   assign half      = cnt_ff >> 1;
   assign probe_sum = first_ff + half;
   assign stat.search_done = (cnt_ff == '0);

   always_comb begin
      first_in = first_ff;
      cnt_in   = cnt_ff;
      if (cmd.dispatch) begin
         first_in = '0;
         cnt_in   = count_ff;
      end else if (cmd.compare) begin
         if (e_rd_ff <= res_energy_ff) begin
            first_in = probe_sum + CountWidth'(1);
            cnt_in   = cnt_ff - half - CountWidth'(1);
         end else begin
            cnt_in = half;
         end
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
      cnt_ff   <= cnt_in;
   end

   // Upper bracket index, held inside the table.
   assign last_idx = count_ff - CountWidth'(1);
   always_comb begin
      if (first_ff < CountWidth'(1)) begin
         hi_calc = CountWidth'(1);
      end else if (first_ff > last_idx) begin
         hi_calc = last_idx;
      end else begin
         hi_calc = first_ff;
      end
   end

   // Table read port address.
   always_comb begin
      rd_addr = hi_ff;
      if (cmd.probe) begin
         rd_addr = probe_sum[AddrWidth-1:0];
      end else if (cmd.fetch_lo) begin
         rd_addr = hi_calc[AddrWidth-1:0] - AddrWidth'(1);
      end
   end
   assign rd_en = cmd.probe || cmd.fetch_lo || cmd.fetch_hi;

   // Table memories: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         energy_mem[count_ff[AddrWidth-1:0]] <= pe_ff;
         sigma_mem[count_ff[AddrWidth-1:0]]  <= ps_ff;
      end
      if (rd_en) begin
         e_rd_ff <= energy_mem[rd_addr];
         s_rd_ff <= sigma_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch_lo) begin
         hi_ff <= hi_calc[AddrWidth-1:0];
      end
      if (cmd.fetch_hi) begin
         e0_ff <= e_rd_ff;
         s0_ff <= s_rd_ff;
      end
   end

   // Interpolation operands. A bracket without positive width gives a zero
   // numerator over a unit divisor, so the lower sigma comes out unchanged.
   assign flat  = (e_rd_ff <= e0_ff);
   assign den_c = flat ? W'(1) : (e_rd_ff - e0_ff);
   always_comb begin
      if (flat || (res_energy_ff <= e0_ff)) begin
         num_c = '0;
      end else begin
         num_c = res_energy_ff - e0_ff;
      end
      if (num_c > den_c) begin
         num_c = den_c;
      end
   end
   assign diff_c = flat ? '0 :
                   ((s_rd_ff >= s0_ff) ? (s_rd_ff - s0_ff) : (s0_ff - s_rd_ff));

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         den_ff  <= den_c;
         num_ff  <= num_c;
         diff_ff <= diff_c;
         down_ff <= (s_rd_ff < s0_ff);
      end
      if (cmd.mul) begin
         prod_ff <= num_ff * diff_ff;
      end
   end

   // Restoring divider. The numerator is below den * 2^32, so the upper
   // half starts below the divisor and 32 steps give the whole quotient.
   assign dividend   = prod_ff + {{W{1'b0}}, (den_ff >> 1)};
   assign trial      = {rem_ff, low_ff[W-1]};
   assign trial_sub  = trial - {1'b0, den_ff};
   assign trial_fits = (trial >= {1'b0, den_ff});
   assign stat.div_last = (div_cnt_ff == DIV_COUNT_WIDTH'(DIV_STEPS - 1));

   always_comb begin
      rem_in     = rem_ff;
      low_in     = low_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.div_setup) begin
         rem_in     = dividend[2*W-1:W];
         low_in     = dividend[W-1:0];
         div_cnt_in = '0;
      end else if (cmd.divide) begin
         rem_in     = trial_fits ? trial_sub[W-1:0] : trial[W-1:0];
         low_in     = {low_ff[W-2:0], trial_fits};
         div_cnt_in = div_cnt_ff + DIV_COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      low_ff     <= low_in;
      div_cnt_ff <= div_cnt_in;
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_grid_energy <= res_energy_ff;
         rsp_grid_sigma  <= res_sigma_ff;
         rsp_last_point  <= res_last_ff;
         rsp_status      <= res_status_ff;
      end
   end

endmodule : uglr_datapath
`default_nettype wire

>>> rtl/core/uglr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Uniform grid resampler checker
// Port-level properties of the resampler, attached to the top level by bind.
// ----------------------------------------------------------------------------
module uglr_checker
   import uglr_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [DATA_WIDTH-1:0] rsp_grid_energy,
   input wire logic [DATA_WIDTH-1:0] rsp_grid_sigma,
   input wire logic                  rsp_last_point,
   input wire logic [1:0]            rsp_status
);

   // A stalled response keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_grid_energy)
         && $stable(rsp_grid_sigma) && $stable(rsp_last_point) && $stable(rsp_status))
      else $error("stalled response changed");

   // Only one request is in work: the input closes after each acceptance.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in work");

   // Responses with an error status carry no grid point.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK)
         |-> (rsp_grid_energy == '0) && (rsp_grid_sigma == '0) && !rsp_last_point)
      else $error("error response carries a grid point");

   // The last flag only ever comes with a good status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_point |-> (rsp_status == STATUS_OK))
      else $error("last point with error status");

endmodule : uglr_checker

bind uniform_grid_linear_resampler uglr_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_grid_energy (rsp_grid_energy),
   .rsp_grid_sigma  (rsp_grid_sigma),
   .rsp_last_point  (rsp_last_point),
   .rsp_status      (rsp_status)
);
`default_nettype wire

>>> tb/sv/tb_uniform_grid_linear_resampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the uniform grid linear resampler
// Drives load, read, clear and unused requests through the valid/ready
// request channel, writes the energy step between phases, and compares every
// response field by field against a cycle-free model of the table, the grid
// walk and the rounded linear interpolation. Both channels idle at random,
// the receiver holds off for a long stretch at least once, and one phase fills the
// table to capacity and beyond.
// ----------------------------------------------------------------------------

// One response of the block, as predicted or as observed.
typedef struct packed {
   logic [31:0] energy;
   logic [31:0] sigma;
   logic        last;
   logic [1:0]  status;
} grid_point_type;

// Tracks the table and the grid position, and holds the responses still due.
class grid_point_tracker;
   logic [31:0] energy_tab [uglr_pkg::UGLR_TABLE_DEPTH];
   logic [31:0] sigma_tab  [uglr_pkg::UGLR_TABLE_DEPTH];
   int unsigned point_total;
   logic [32:0] offset;
   bit          finished;
   logic [31:0] step;
   grid_point_type expected_points [$];
   int unsigned mismatches;

   function new();
      point_total = 0;
      offset      = '0;
      finished    = 1'b0;
      step        = uglr_pkg::STEP_RESET;
      mismatches  = 0;
   endfunction

   function void set_step(logic [31:0] value);
      step = value;
   endfunction

   function int unsigned pending();
      return expected_points.size();
   endfunction

   function bit grid_done();
      return finished;
   endfunction

   // First table index whose energy lies above e.
   function int unsigned first_above(logic [31:0] e);
      int unsigned first;
      int unsigned cnt;
      int unsigned half;
      int unsigned probe;
      first = 0;
      cnt   = point_total;
      while (cnt > 0) begin
         half  = cnt / 2;
         probe = first + half;
         if (energy_tab[probe] <= e) begin
            first = probe + 1;
            cnt   = cnt - half - 1;
         end else begin
            cnt = half;
         end
      end
      return first;
   endfunction

   // Sigma at energy e, clamped at the table ends and rounded to nearest.
   function logic [31:0] sigma_at(logic [31:0] e);
      int unsigned hi;
      int unsigned lo;
      logic [31:0] e0, e1, s0, s1;
      logic [63:0] num, den, diff, q;
      if (e <= energy_tab[0]) return sigma_tab[0];
      if (e >= energy_tab[point_total-1]) return sigma_tab[point_total-1];
      hi = first_above(e);
      if (hi < 1) hi = 1;
      if (hi > point_total - 1) hi = point_total - 1;
      lo = hi - 1;
      e0 = energy_tab[lo];
      e1 = energy_tab[hi];
      s0 = sigma_tab[lo];
      s1 = sigma_tab[hi];
      // A bracket of no positive width gives its lower sigma.
      if (e1 <= e0) return s0;
      den  = 64'(e1) - 64'(e0);
      num  = (e > e0) ? 64'(e) - 64'(e0) : 64'd0;
      if (num > den) num = den;
      diff = (s1 >= s0) ? 64'(s1) - 64'(s0) : 64'(s0) - 64'(s1);
      q    = (num * diff + den / 2) / den;
      if (s1 >= s0) return 32'(64'(s0) + q);
      return 32'(64'(s0) - q);
   endfunction

   // Works out the response to an accepted request and queues it.
   function void note_request(logic [1:0] action, logic [31:0] pe, logic [31:0] ps);
      grid_point_type r;
      logic [63:0] e;
      logic [31:0] emin, emax, stp;
      r = '0;
      case (action)
         uglr_pkg::ACT_LOAD: begin
            if (point_total < uglr_pkg::UGLR_TABLE_DEPTH) begin
               energy_tab[point_total] = pe;
               sigma_tab[point_total]  = ps;
               point_total++;
            end else begin
               r.status = uglr_pkg::STATUS_FULL;
            end
            offset   = '0;
            finished = 1'b0;
         end
         uglr_pkg::ACT_CLEAR: begin
            point_total = 0;
            offset      = '0;
            finished    = 1'b0;
         end
         uglr_pkg::ACT_READ: begin
            if (point_total < 2) begin
               r.status = uglr_pkg::STATUS_FEW;
            end else if (finished) begin
               r.status = uglr_pkg::STATUS_FINISHED;
            end else begin
               emin = energy_tab[0];
               emax = energy_tab[point_total-1];
               e    = 64'(emin) + 64'(offset);
               stp  = (step == '0) ? 32'd1 : step;
               // The final point is exactly the last table energy.
               if (e >= 64'(emax)) begin
                  r.energy = emax;
                  r.last   = 1'b1;
                  finished = 1'b1;
               end else begin
                  r.energy = e[31:0];
                  offset   = offset + 33'(stp);
               end
               r.sigma = sigma_at(r.energy);
            end
         end
         default: begin
            // The unused action changes nothing and answers with zeros.
         end
      endcase
      expected_points = {expected_points, r};
   endfunction

   // Compares one observed response with the oldest one due.
   function void check_response(grid_point_type got);
      grid_point_type want;
      if (expected_points.size() == 0) begin
         $error("response with no request outstanding: energy %h sigma %h status %0d",
                got.energy, got.sigma, got.status);
         mismatches++;
         return;
      end
      want = expected_points.pop_front();
      if (got.energy !== want.energy) begin
         $error("grid_energy: expected %h, actual %h", want.energy, got.energy);
         mismatches++;
      end
      if (got.sigma !== want.sigma) begin
         $error("grid_sigma: expected %h, actual %h", want.sigma, got.sigma);
         mismatches++;
      end
      if (got.last !== want.last) begin
         $error("last_point: expected %b, actual %b", want.last, got.last);
         mismatches++;
      end
      if (got.status !== want.status) begin
         $error("status: expected %0d, actual %0d", want.status, got.status);
         mismatches++;
      end
   endfunction
endclass

module tb_uniform_grid_linear_resampler;
   import uglr_pkg::*;

   localparam logic [1:0]  ACT_UNUSED      = 2'd3;
   localparam int unsigned CYCLE_LIMIT     = 1_000_000;
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   localparam int unsigned SETTLE_CYCLES   = 80;
   localparam int unsigned MAX_READS       = 40;
   localparam int unsigned ITEM_TARGET     = 1500;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_action = ACT_LOAD;
   logic [DATA_WIDTH-1:0] req_point_energy = '0;
   logic [DATA_WIDTH-1:0] req_point_sigma = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [DATA_WIDTH-1:0] rsp_grid_energy;
   logic [DATA_WIDTH-1:0] rsp_grid_sigma;
   logic                  rsp_last_point;
   logic [1:0]            rsp_status;
   logic                  csr_wr_en = 1'b0;
   logic [DATA_WIDTH-1:0] csr_wr_data = '0;

   grid_point_tracker tracker;
   bit          valid_up = 1'b0;
   bit          tx_steady = 1'b0;
   bit          rx_steady = 1'b0;
   int unsigned hold_off_asks = 0;
   int unsigned requests_sent = 0;
   int unsigned cycles = 0;
   logic [31:0] plan_energy [$];
   logic [31:0] plan_sigma [$];

   uniform_grid_linear_resampler u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_point_energy (req_point_energy),
      .req_point_sigma  (req_point_sigma),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_grid_energy  (rsp_grid_energy),
      .rsp_grid_sigma   (rsp_grid_sigma),
      .rsp_last_point   (rsp_last_point),
      .rsp_status       (rsp_status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   // Free-running clock, 10 ns period.
   initial begin
      forever #5 clock = ~clock;
   end

   // Run limit in cycles.
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("uniform_grid_linear_resampler: mismatch");
      $finish;
   end

   // Receiver: random stalls, steady stretches, and one long hold-off per ask.
   initial begin : receiver
      int unsigned holds_seen;
      holds_seen = 0;
      forever begin
         @(posedge clock);
         if (hold_off_asks != holds_seen) begin
            holds_seen = hold_off_asks;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (rx_steady) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 25);
         end
      end
   end

   // Every accepted response goes to the checker.
   always @(posedge clock) begin : response_monitor
      grid_point_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = {rsp_grid_energy, rsp_grid_sigma, rsp_last_point, rsp_status};
         tracker.check_response(seen);
      end
   end

   task automatic drop_valid();
      if (valid_up) begin
         req_valid <= 1'b0;
         valid_up = 1'b0;
      end
   endtask

   // Offers one request, waits for its acceptance and sometimes idles after.
   task automatic send_request(input logic [1:0] action, input logic [31:0] pe,
                               input logic [31:0] ps);
      if (!valid_up) begin
         req_valid <= 1'b1;
         valid_up = 1'b1;
      end
      req_action       <= action;
      req_point_energy <= pe;
      req_point_sigma  <= ps;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_request(action, pe, ps);
      requests_sent++;
      if (!tx_steady && $urandom_range(99) < 25) begin
         drop_valid();
         if ($urandom_range(9) == 0) repeat ($urandom_range(70, 9)) @(posedge clock);
         else repeat ($urandom_range(8, 1)) @(posedge clock);
      end
   endtask

   // Stops offering until every response due has arrived and the block is idle.
   task automatic drain_results();
      drop_valid();
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_step(input logic [31:0] value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.set_step(value);
   endtask

   task automatic send_read();
      send_request(ACT_READ, $urandom, $urandom);
   endtask

   // Walks the grid to its end, within a bound, then may read past its end.
   task automatic read_grid();
      int unsigned reads;
      reads = 0;
      while (!tracker.grid_done() && reads < MAX_READS) begin
         send_read();
         reads++;
         // Now and then a load lands mid-grid and restarts it.
         if ($urandom_range(49) == 0) send_request(ACT_LOAD, $urandom, $urandom);
      end
      if (tracker.grid_done()) repeat ($urandom_range(2)) send_read();
   endtask

   task automatic load_plan();
      foreach (plan_energy[i]) send_request(ACT_LOAD, plan_energy[i], plan_sigma[i]);
   endtask

   // One table of n points, a step sized to it, and a walk over the grid.
   task automatic run_sequence(input int unsigned n, input bit sorted_table,
                               input bit hold_off);
      logic [63:0] lo, width, span;
      logic [31:0] stp, base;
      int unsigned sigma_mode;
      plan_energy.delete();
      plan_sigma.delete();
      case ($urandom_range(3))
         0: width = 64'($urandom_range(200, 1));
         1: width = 64'($urandom_range(32'h0010_0000, 16));
         2: width = 64'($urandom);
         default: width = 64'hFFFF_FFFF;
      endcase
      lo = 64'($urandom) % (64'hFFFF_FFFF - width + 1);
      for (int unsigned i = 0; i < n; i++) begin
         if (i > 0 && $urandom_range(9) == 0) plan_energy = {plan_energy, plan_energy[i-1]};
         else plan_energy = {plan_energy, 32'(lo + 64'($urandom) % (width + 1))};
      end
      if (sorted_table) plan_energy.sort();
      sigma_mode = $urandom_range(3);
      base = $urandom;
      for (int unsigned i = 0; i < n; i++) begin
         case (sigma_mode)
            0: plan_sigma = {plan_sigma, 32'($urandom)};
            1: plan_sigma = {plan_sigma, base ^ 32'($urandom_range(255))};
            2: plan_sigma = {plan_sigma, base};
            default: plan_sigma = {plan_sigma, (i % 2 == 0) ? 32'h0 : 32'hFFFF_FFFF};
         endcase
      end
      span = 0;
      if (n >= 2 && plan_energy[n-1] > plan_energy[0])
         span = 64'(plan_energy[n-1]) - 64'(plan_energy[0]);
      // Mostly the span over 1 to 24, plus 0 to 3; at times zero, one or all ones.
      case ($urandom_range(19))
         0: stp = '0;
         1: stp = '1;
         2: stp = 32'd1;
         default: stp = 32'(span / 64'($urandom_range(24, 1))) + 32'($urandom_range(3));
      endcase
      if ($urandom_range(99) < 70) write_step(stp);
      if ($urandom_range(9) != 0) send_request(ACT_CLEAR, $urandom, $urandom);
      if (hold_off) hold_off_asks++;
      load_plan();
      read_grid();
   endtask

   // Random requests of every kind, tables out of order among them.
   task automatic run_noise(input int unsigned count);
      if ($urandom_range(1) == 0) send_request(ACT_CLEAR, $urandom, $urandom);
      repeat (count) send_request(2'($urandom_range(3)), $urandom, $urandom);
   endtask

   // Fills the table to capacity, overflows it, and walks the full table.
   task automatic fill_table();
      logic [31:0] stp;
      plan_energy.delete();
      plan_sigma.delete();
      for (int unsigned i = 0; i < UGLR_TABLE_DEPTH; i++) begin
         plan_energy = {plan_energy, 32'($urandom)};
         plan_sigma  = {plan_sigma, 32'($urandom)};
      end
      plan_energy.sort();
      stp = (plan_energy[UGLR_TABLE_DEPTH-1] - plan_energy[0])
            / 32'($urandom_range(30, 8)) + 32'd1;
      write_step(stp);
      tx_steady = 1'b1;
      rx_steady = 1'b1;
      send_request(ACT_CLEAR, $urandom, $urandom);
      load_plan();
      repeat (3) send_request(ACT_LOAD, $urandom, $urandom);
      read_grid();
      tx_steady = 1'b0;
      rx_steady = 1'b0;
   endtask

   // Main stimulus: directed cases, then random phases, then the verdict.
   initial begin : stimulus
      int unsigned seq;
      int unsigned n;
      tracker = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Unused action and reads of an empty and a single-point table.
      send_request(ACT_UNUSED, '1, '1);
      send_request(ACT_READ, '0, '0);
      send_request(ACT_LOAD, 32'h0001_0000, 32'd101);
      send_read();
      // Falling sigma with a rounding tie at the midpoint, then past the end.
      send_request(ACT_LOAD, 32'h0003_0000, 32'd50);
      repeat (4) send_read();
      // A load restarts the grid; the final point falls between grid steps.
      send_request(ACT_LOAD, 32'h0003_8000, 32'hFFFF_FFFF);
      repeat (5) send_read();
      send_request(ACT_CLEAR, $urandom, $urandom);
      // A step of zero behaves as a step of one.
      write_step('0);
      send_request(ACT_LOAD, '0, '0);
      send_request(ACT_LOAD, 32'd3, '1);
      repeat (5) send_read();
      // Largest step across the full energy range.
      write_step('1);
      send_request(ACT_CLEAR, $urandom, $urandom);
      send_request(ACT_LOAD, '0, 32'd7);
      send_request(ACT_LOAD, '1, '0);
      repeat (3) send_read();

      seq = 0;
      while (requests_sent < ITEM_TARGET) begin
         if (seq == 4) begin
            fill_table();
         end else if (seq % 6 == 5) begin
            run_noise($urandom_range(40, 10));
         end else begin
            if ($urandom_range(19) == 0) n = 1;
            else if ($urandom_range(4) == 0) n = $urandom_range(40, 9);
            else n = $urandom_range(8, 2);
            tx_steady = ($urandom_range(9) == 0);
            run_sequence(n, $urandom_range(9) != 0, seq == 2 || $urandom_range(49) == 0);
            tx_steady = 1'b0;
         end
         seq++;
      end

      drain_results();
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("uniform_grid_linear_resampler: match");
      else
         $display("uniform_grid_linear_resampler: mismatch");
      $finish;
   end

endmodule
